// File: rtl/btpc_pkg.sv
// ============================================================================
// btpc_pkg: shared types, constants and helpers for the barometric
// temperature and pressure compensation pipeline.
// ============================================================================
`default_nettype none

package btpc_pkg;

  // Width of the signed pressure divide.
  localparam int DIV_W = 64;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TEMP_CAL   = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_NINE = 3'd3;

  // Temperature limits in hundredths of a degree.
  localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX = 15'sd8500;

  // Control and sideband data that travels through the divider.
  typedef struct packed {
    logic                vld;
    logic                zero;
    logic signed [14:0]  temp;
  } side_t;

  // Unsigned 32-bit word times signed 16-bit value, exact, sign-extended to 64.
  function automatic logic [63:0] mul_lo(input logic [31:0] a, input logic signed [15:0] b);
    logic signed [48:0] pr;
    pr = $signed({1'b0, a}) * b;
    return {{15{pr[48]}}, pr};
  endfunction

  // Low 32 bits of a 32-bit word times a 16-bit value, sign-extended when b_signed is set.
  function automatic logic [31:0] mul_hi32(input logic [31:0] a, input logic [15:0] b,
                                           input logic b_signed);
    logic [63:0] pr;
    pr = a * {{16{b_signed & b[15]}}, b};
    return pr[31:0];
  endfunction

  // Unsigned 32-bit word times unsigned 16-bit value, zero-extended to 64.
  function automatic logic [63:0] mul_lou(input logic [31:0] a, input logic [15:0] b);
    logic [47:0] pr;
    pr = a * b;
    return {16'd0, pr};
  endfunction

endpackage

`default_nettype wire

// File: rtl/btpc_div.sv
// ============================================================================
// btpc_div: pipelined signed divider
// One quotient bit per stage; truncates toward zero.
// ============================================================================
`default_nettype none

module btpc_div #(
  parameter int W = btpc_pkg::DIV_W
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic [W-1:0]        num,
  input  wire logic [W-1:0]        den,
  input  wire btpc_pkg::side_t     side_in,
  output logic [W-1:0]             quo,
  output btpc_pkg::side_t          side_out
);

  logic [W-1:0]    rem  [0:W];
  logic [W-1:0]    nq   [0:W];
  logic [W-1:0]    dmag [0:W];
  logic            neg  [0:W];
  btpc_pkg::side_t side [0:W];

  // Entry stage: magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      side[0] <= '0;
    end else if (en) begin
      side[0] <= side_in;
    end
    if (en) begin
      rem[0]  <= '0;
      nq[0]   <= num[W-1] ? (~num + 1'b1) : num;
      dmag[0] <= den[W-1] ? (~den + 1'b1) : den;
      neg[0]  <= num[W-1] ^ den[W-1];
    end
  end

  genvar k;
  generate
    for (k = 1; k <= W; k++) begin : g_step
      logic [W:0] shifted;
      logic [W:0] diff;
      assign shifted = {rem[k-1], nq[k-1][W-1]};
      assign diff    = shifted - {1'b0, dmag[k-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          side[k] <= '0;
        end else if (en) begin
          side[k] <= side[k-1];
        end
        if (en) begin
          if (!diff[W]) begin
            rem[k] <= diff[W-1:0];
            nq[k]  <= {nq[k-1][W-2:0], 1'b1};
          end else begin
            rem[k] <= shifted[W-1:0];
            nq[k]  <= {nq[k-1][W-2:0], 1'b0};
          end
          dmag[k] <= dmag[k-1];
          neg[k]  <= neg[k-1];
        end
      end
    end
  endgenerate

  // Sign correction stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side[W];
    end
    if (en) begin
      quo <= neg[W] ? (~nq[W] + 1'b1) : nq[W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/baro_temp_pressure_compensation_top.sv
// ============================================================================
// baro_temp_pressure_compensation_top: barometric sensor compensation
// Turns raw 20-bit temperature and pressure conversions into temperature in
// hundredths of a degree and pressure in pascal (Q24.8) using the factory
// calibration coefficients held in configuration registers.
// ============================================================================
//
//  Channel  | Signals                                         | Direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid/in_ready, raw_temperature, raw_pressure | in
//  result   | out_valid/out_ready, temperature_centi,          | out
//           | pressure_q24_8, pressure_valid                   |
//  config   | cfg_write, cfg_index, cfg_data                   | in
//
// One transfer is accepted per cycle while the output register is empty or being
// taken; each item passes through the 66-stage radix-2 pressure divider, with ten
// stages in front of it and five behind it.
// All stages advance together whenever the output register is empty or is
// being taken, so a stall freezes every stage in place.
// Reset (synchronous, active high) clears all valid bits, the calibration
// registers and the fine temperature.
//
// Front stages:
//   S1..S3 compute the fine temperature, which is held in fine_temperature.
//   S4 gives the saturated temperature and the offset fine temperature.
//   S5..S10 build the pressure numerator and divisor with products cut into
//   32-bit partials, wrapping modulo 2^64.
// Back stages Q1..Q4 apply the second-order pressure correction, and the
// output register adds the final offset.

`default_nettype none

module baro_temp_pressure_compensation_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [19:0]        raw_temperature,
  input  wire logic [19:0]        raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [14:0]      temperature_centi,
  output logic [31:0]             pressure_q24_8,
  output logic                    pressure_valid,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [47:0] temp_cal;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [15:0] press_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal   <= '0;
      press_low  <= '0;
      press_high <= '0;
      press_nine <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        btpc_pkg::CFG_TEMP_CAL:   temp_cal   <= cfg_data[47:0];
        btpc_pkg::CFG_PRESS_LOW:  press_low  <= cfg_data;
        btpc_pkg::CFG_PRESS_HIGH: press_high <= cfg_data;
        btpc_pkg::CFG_PRESS_NINE: press_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_cal[15:0];
  assign t2 = $signed(temp_cal[31:16]);
  assign t3 = $signed(temp_cal[47:32]);
  assign p1 = press_low[15:0];
  assign p2 = $signed(press_low[31:16]);
  assign p3 = $signed(press_low[47:32]);
  assign p4 = $signed(press_low[63:48]);
  assign p5 = $signed(press_high[15:0]);
  assign p6 = $signed(press_high[31:16]);
  assign p7 = $signed(press_high[47:32]);
  assign p8 = $signed(press_high[63:48]);
  assign p9 = $signed(press_nine);

  // Every stage moves when the output register can take a new result.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // --------------------------------------------------------------------------
  // S1: first temperature products
  // --------------------------------------------------------------------------
  logic signed [17:0] ta, td;
  logic signed [35:0] td_sq;
  assign ta    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td    = $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, t1});
  assign td_sq = td * td;

  logic               s1_vld;
  logic [19:0]        s1_adcp;
  logic signed [33:0] s1_prod;
  logic [31:0]        s1_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
    if (en) begin
      s1_adcp <= raw_pressure;
      s1_prod <= ta * t2;
      s1_sq   <= td_sq[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // S2: second-order temperature term
  // --------------------------------------------------------------------------
  logic signed [33:0] s1_prod_sh;
  assign s1_prod_sh = s1_prod >>> 11;

  logic               s2_vld;
  logic [19:0]        s2_adcp;
  logic signed [22:0] s2_v1;
  logic signed [36:0] s2_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
    if (en) begin
      s2_adcp <= s1_adcp;
      s2_v1   <= s1_prod_sh[22:0];
      s2_x    <= $signed({1'b0, s1_sq[31:12]}) * t3;
    end
  end

  // --------------------------------------------------------------------------
  // S3: fine temperature
  // --------------------------------------------------------------------------
  logic signed [36:0] s2_x_sh;
  logic signed [23:0] fine_sum;
  logic        [31:0] fine_temperature_next;
  assign s2_x_sh               = s2_x >>> 14;
  assign fine_sum              = {s2_v1[22], s2_v1} + {s2_x_sh[22], s2_x_sh[22:0]};
  assign fine_temperature_next = {{8{fine_sum[23]}}, fine_sum};

  logic        s3_vld;
  logic [19:0] s3_adcp;
  logic [31:0] fine_temperature;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld           <= 1'b0;
      fine_temperature <= '0;
    end else if (en) begin
      s3_vld <= s2_vld;
      if (s2_vld) begin
        fine_temperature <= fine_temperature_next;
      end
    end
    if (en) begin
      s3_adcp <= s2_adcp;
    end
  end

  // --------------------------------------------------------------------------
  // S4: temperature in hundredths and offset fine temperature
  // --------------------------------------------------------------------------
  logic signed [34:0] f35, t5, tv;
  logic signed [14:0] temp_sat;
  assign f35 = $signed({{3{fine_temperature[31]}}, fine_temperature});
  assign t5  = (f35 <<< 2) + f35 + 35'sd128;
  assign tv  = t5 >>> 8;

  always_comb begin
    priority if (tv < -35'sd4000) begin
      temp_sat = btpc_pkg::TEMP_MIN;
    end else if (tv > 35'sd8500) begin
      temp_sat = btpc_pkg::TEMP_MAX;
    end else begin
      temp_sat = tv[14:0];
    end
  end

  logic               s4_vld;
  logic [19:0]        s4_adcp;
  logic signed [14:0] s4_temp;
  logic signed [32:0] s4_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
    if (en) begin
      s4_adcp <= s3_adcp;
      s4_temp <= temp_sat;
      s4_w    <= $signed({fine_temperature[31], fine_temperature}) - 33'sd128000;
    end
  end

  // --------------------------------------------------------------------------
  // S5: square of the offset and the first-order pressure products
  // --------------------------------------------------------------------------
  logic signed [65:0] w_sq;
  assign w_sq = s4_w * s4_w;

  logic               s5_vld;
  logic [19:0]        s5_adcp;
  logic signed [14:0] s5_temp;
  logic [63:0]        s5_a;
  logic signed [48:0] s5_b5, s5_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
    if (en) begin
      s5_adcp <= s4_adcp;
      s5_temp <= s4_temp;
      s5_a    <= w_sq[63:0];
      s5_b5   <= s4_w * p5;
      s5_b2   <= s4_w * p2;
    end
  end

  // --------------------------------------------------------------------------
  // S6: partial products of the square with P6 and P3
  // --------------------------------------------------------------------------
  logic               s6_vld;
  logic [19:0]        s6_adcp;
  logic signed [14:0] s6_temp;
  logic [63:0]        s6_m6l, s6_m3l, s6_b5s, s6_b2s;
  logic [31:0]        s6_m6h, s6_m3h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s5_vld;
    end
    if (en) begin
      s6_adcp <= s5_adcp;
      s6_temp <= s5_temp;
      s6_m6l  <= btpc_pkg::mul_lo(s5_a[31:0], p6);
      s6_m6h  <= btpc_pkg::mul_hi32(s5_a[63:32], p6, 1'b1);
      s6_m3l  <= btpc_pkg::mul_lo(s5_a[31:0], p3);
      s6_m3h  <= btpc_pkg::mul_hi32(s5_a[63:32], p3, 1'b1);
      s6_b5s  <= {{15{s5_b5[48]}}, s5_b5} << 17;
      s6_b2s  <= {{15{s5_b2[48]}}, s5_b2} << 12;
    end
  end

  // --------------------------------------------------------------------------
  // S7: pressure terms v2 and v1
  // --------------------------------------------------------------------------
  logic [63:0] a3_prod;
  assign a3_prod = s6_m3l + {s6_m3h, 32'd0};

  logic               s7_vld;
  logic [19:0]        s7_adcp;
  logic signed [14:0] s7_temp;
  logic [63:0]        s7_v2, s7_v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= s6_vld;
    end
    if (en) begin
      s7_adcp <= s6_adcp;
      s7_temp <= s6_temp;
      s7_v2   <= s6_m6l + {s6_m6h, 32'd0} + s6_b5s + ({{48{p4[15]}}, p4} << 35);
      s7_v1   <= 64'($signed(a3_prod) >>> 8) + s6_b2s;
    end
  end

  // --------------------------------------------------------------------------
  // S8: divisor base and numerator base
  // --------------------------------------------------------------------------
  logic [20:0] pp;
  assign pp = 21'd1048576 - {1'b0, s7_adcp};

  logic               s8_vld;
  logic signed [14:0] s8_temp;
  logic [63:0]        s8_u, s8_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (en) begin
      s8_vld <= s7_vld;
    end
    if (en) begin
      s8_temp <= s7_temp;
      s8_u    <= 64'h0000_8000_0000_0000 + s7_v1;
      s8_n    <= ({43'd0, pp} << 31) - s7_v2;
    end
  end

  // --------------------------------------------------------------------------
  // S9: partial products with P1 and with 3125
  // --------------------------------------------------------------------------
  logic               s9_vld;
  logic signed [14:0] s9_temp;
  logic [63:0]        s9_ul, s9_nl;
  logic [31:0]        s9_uh, s9_nh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (en) begin
      s9_vld <= s8_vld;
    end
    if (en) begin
      s9_temp <= s8_temp;
      s9_ul   <= btpc_pkg::mul_lou(s8_u[31:0], p1);
      s9_uh   <= btpc_pkg::mul_hi32(s8_u[63:32], p1, 1'b0);
      s9_nl   <= btpc_pkg::mul_lou(s8_n[31:0], 16'd3125);
      s9_nh   <= btpc_pkg::mul_hi32(s8_n[63:32], 16'd3125, 1'b0);
    end
  end

  // --------------------------------------------------------------------------
  // S10: divisor, numerator and zero-divisor flag
  // --------------------------------------------------------------------------
  logic [63:0] u_prod, den_next;
  assign u_prod   = s9_ul + {s9_uh, 32'd0};
  assign den_next = 64'($signed(u_prod) >>> 33);

  btpc_pkg::side_t s10_side;
  logic [63:0]     s10_num, s10_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_side.vld <= 1'b0;
    end else if (en) begin
      s10_side.vld <= s9_vld;
    end
    if (en) begin
      s10_side.zero <= (den_next == 64'd0);
      s10_side.temp <= s9_temp;
      s10_num       <= s9_nl + {s9_nh, 32'd0};
      s10_den       <= den_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pipelined signed divide
  // --------------------------------------------------------------------------
  logic [btpc_pkg::DIV_W-1:0] div_quo;
  btpc_pkg::side_t            div_side;

  btpc_div #(
    .W (btpc_pkg::DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (s10_num[btpc_pkg::DIV_W-1:0]),
    .den      (s10_den[btpc_pkg::DIV_W-1:0]),
    .side_in  (s10_side),
    .quo      (div_quo),
    .side_out (div_side)
  );

  logic [63:0] pq;
  assign pq = 64'(div_quo);

  // --------------------------------------------------------------------------
  // Q1: partial products of P9 and P8
  // --------------------------------------------------------------------------
  logic [63:0] pq_sh;
  assign pq_sh = 64'($signed(pq) >>> 13);

  btpc_pkg::side_t q1_side;
  logic [63:0]     q1_p, q1_q, q1_rl, q1_sl;
  logic [31:0]     q1_rh, q1_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_side <= '0;
    end else if (en) begin
      q1_side <= div_side;
    end
    if (en) begin
      q1_p  <= pq;
      q1_q  <= pq_sh;
      q1_rl <= btpc_pkg::mul_lo(pq_sh[31:0], p9);
      q1_rh <= btpc_pkg::mul_hi32(pq_sh[63:32], p9, 1'b1);
      q1_sl <= btpc_pkg::mul_lo(pq[31:0], p8);
      q1_sh <= btpc_pkg::mul_hi32(pq[63:32], p8, 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Q2: P9 product and the P8 correction
  // --------------------------------------------------------------------------
  logic [63:0] s8_prod;
  assign s8_prod = q1_sl + {q1_sh, 32'd0};

  btpc_pkg::side_t q2_side;
  logic [63:0]     q2_p, q2_q, q2_r, q2_v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_side <= '0;
    end else if (en) begin
      q2_side <= q1_side;
    end
    if (en) begin
      q2_p  <= q1_p;
      q2_q  <= q1_q;
      q2_r  <= q1_rl + {q1_rh, 32'd0};
      q2_v2 <= 64'($signed(s8_prod) >>> 19);
    end
  end

  // --------------------------------------------------------------------------
  // Q3: partials of the second P9 product
  // --------------------------------------------------------------------------
  logic [63:0] lh_full, hl_full;
  assign lh_full = q2_r[31:0] * q2_q[63:32];
  assign hl_full = q2_r[63:32] * q2_q[31:0];

  btpc_pkg::side_t q3_side;
  logic [63:0]     q3_p, q3_v2, q3_ll;
  logic [31:0]     q3_lh, q3_hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      q3_side <= '0;
    end else if (en) begin
      q3_side <= q2_side;
    end
    if (en) begin
      q3_p  <= q2_p;
      q3_v2 <= q2_v2;
      q3_ll <= q2_r[31:0] * q2_q[31:0];
      q3_lh <= lh_full[31:0];
      q3_hl <= hl_full[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Q4: P9 correction
  // --------------------------------------------------------------------------
  logic [63:0] rq_prod;
  logic [31:0] rq_cross;
  assign rq_cross = q3_lh + q3_hl;
  assign rq_prod  = q3_ll + {rq_cross, 32'd0};

  btpc_pkg::side_t q4_side;
  logic [63:0]     q4_p, q4_v1, q4_v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      q4_side <= '0;
    end else if (en) begin
      q4_side <= q3_side;
    end
    if (en) begin
      q4_p  <= q3_p;
      q4_v1 <= 64'($signed(rq_prod) >>> 25);
      q4_v2 <= q3_v2;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: final offset and zero-divisor handling
  // --------------------------------------------------------------------------
  logic [63:0] p_sum, p_final;
  assign p_sum   = q4_p + q4_v1 + q4_v2;
  assign p_final = 64'($signed(p_sum) >>> 8) + ({{48{p7[15]}}, p7} << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q4_side.vld;
    end
    if (en) begin
      temperature_centi <= q4_side.temp;
      pressure_q24_8    <= q4_side.zero ? 32'd0 : p_final[31:0];
      pressure_valid    <= !q4_side.zero;
    end
  end

endmodule

`default_nettype wire

// File: rtl/btpc_checker.sv
// ============================================================================
// btpc_checker: port-level checks for the compensation pipeline
// Watches the handshakes and result fields of the top level.
// ============================================================================
`default_nettype none

module btpc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [14:0] temperature_centi,
  input wire logic [31:0]        pressure_q24_8,
  input wire logic               pressure_valid
);

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_q24_8)
      && $stable(temperature_centi) && $stable(pressure_valid))
    else $error("result changed while stalled");

  // The input side only stalls while the output register is blocked.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled without an output stall");

  // A zero divisor gives a zero pressure.
  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_valid |-> pressure_q24_8 == 32'd0)
    else $error("invalid pressure is not zero");

  // Temperature stays within the saturation limits.
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature_centi >= -15'sd4000 && temperature_centi <= 15'sd8500)
    else $error("temperature out of range");

  // Reset clears the output valid.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .temperature_centi (temperature_centi),
  .pressure_q24_8    (pressure_q24_8),
  .pressure_valid    (pressure_valid)
);

`default_nettype wire
